[sv/mcvm_pkg.sv]
package mcvm_pkg;

    localparam int NUM_VOICES_DEF  = 8;
    localparam int TABLE_DEPTH_DEF = 2048;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam logic [17:0] QUARTER_UNITS = 18'd196608;

    // Click kinds, also the voice state codes.
    localparam logic [1:0] KIND_IDLE = 2'd0;
    localparam logic [1:0] KIND_HIGH = 2'd1;
    localparam logic [1:0] KIND_MID  = 2'd2;
    localparam logic [1:0] KIND_SUB  = 2'd3;

    // Table selector codes.
    localparam logic [1:0] SEL_HIGH = 2'd0;
    localparam logic [1:0] SEL_MID  = 2'd1;
    localparam logic [1:0] SEL_SUB  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_ENABLED = 3'd0;
    localparam logic [2:0] REG_SUBDIV  = 3'd1;
    localparam logic [2:0] REG_BEATS   = 3'd2;
    localparam logic [2:0] REG_STEP    = 3'd3;
    localparam logic [2:0] REG_VOLUME  = 3'd4;
    localparam logic [2:0] REG_HLEN    = 3'd5;
    localparam logic [2:0] REG_MLEN    = 3'd6;
    localparam logic [2:0] REG_SLEN    = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIG,
        ST_KIND,
        ST_VOICE,
        ST_WAIT,
        ST_MIX,
        ST_SAT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] len;
    } t_lens;

    // Grid interval for each subdivision code.
    function automatic logic [17:0] grid_interval(input logic [2:0] sub);
        case (sub)
            3'd1:    grid_interval = 18'd196608;
            3'd2:    grid_interval = 18'd98304;
            3'd3:    grid_interval = 18'd49152;
            3'd4:    grid_interval = 18'd65536;
            default: grid_interval = 18'd0;
        endcase
    endfunction

endpackage

[sv/mcvm_mod.sv]
// Serial remainder unit: one quotient bit a cycle, for a 50-bit dividend and
// a divisor below 2^23.
module mcvm_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [49:0] i_num,
    input  logic [22:0] i_den,
    output logic        o_done,
    output logic [22:0] o_rem
);
    import mcvm_pkg::*;

    logic [49:0] r_num;
    logic [23:0] r_rem;
    logic [22:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [23:0] w_shift;

    assign w_shift = {r_rem[22:0], r_num[49]};

    // Restoring step per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd50;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[48:0], 1'b0};
                if (w_shift >= {1'b0, r_den}) begin
                    r_rem <= w_shift - {1'b0, r_den};
                end else begin
                    r_rem <= w_shift;
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_rem = r_rem[22:0];
endmodule

[sv/mcvm_tables.sv]
// Three click tables, one write and one read per cycle, registered read.
module mcvm_tables #(
    parameter int TABLE_DEPTH = mcvm_pkg::TABLE_DEPTH_DEF,
    parameter int SAMPLE_BITS = mcvm_pkg::SAMPLE_BITS_DEF,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [1:0]             i_wsel,
    input  logic [AW-1:0]          i_waddr,
    input  logic [SAMPLE_BITS-1:0] i_wdata,
    input  logic [1:0]             i_rkind,
    input  logic [AW-1:0]          i_raddr,
    output logic [SAMPLE_BITS-1:0] o_rdata
);
    import mcvm_pkg::*;

    logic [SAMPLE_BITS-1:0] r_high [TABLE_DEPTH];
    logic [SAMPLE_BITS-1:0] r_mid  [TABLE_DEPTH];
    logic [SAMPLE_BITS-1:0] r_sub  [TABLE_DEPTH];
    logic [SAMPLE_BITS-1:0] r_dh, r_dm, r_ds;
    logic [1:0]             r_k;

    always_ff @(posedge i_clk) begin
        if (i_we && i_wsel == SEL_HIGH) r_high[i_waddr] <= i_wdata;
        if (i_we && i_wsel == SEL_MID)  r_mid[i_waddr]  <= i_wdata;
        if (i_we && i_wsel == SEL_SUB)  r_sub[i_waddr]  <= i_wdata;
        r_dh <= r_high[i_raddr];
        r_dm <= r_mid[i_raddr];
        r_ds <= r_sub[i_raddr];
        r_k  <= i_rkind;
    end

    always_comb begin
        case (r_k)
            KIND_HIGH: o_rdata = r_dh;
            KIND_MID:  o_rdata = r_dm;
            default:   o_rdata = r_ds;
        endcase
    end
endmodule

[sv/metronome_click_voice_mixer_core.sv]
// Channel | Dir | Fields (lowest bit first)
// s_axis  | in  | tdata: position[47:0] audio_in[63:48] table_address[74:64]
//         |     |        table_value[90:75]; tuser: func[0] table_select[2:1]
// m_axis  | out | tdata: audio_out[15:0]; tuser: click_started[1:0] voice_dropped[2]
// A table write is answered straight from the idle state. An audio sample runs the serial
// remainder unit for the grid search and, on a grid hit, again for the kind test; with
// triggering off both are skipped. Each voice then takes a registered table read in turn.
// The block accepts no new request while one is at work; a result waits until taken.
// Reset is synchronous and active low; it idles all voices and loads the register defaults.
module metronome_click_voice_mixer_core #(
    parameter int NUM_VOICES  = mcvm_pkg::NUM_VOICES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // position, audio_in, table_address, table_value
    input  logic [95:0] s_axis_tdata,
    // func, table_select
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // audio_out
    output logic [15:0] m_axis_tdata,
    // click_started, voice_dropped
    output logic [2:0]  m_axis_tuser
);
    import mcvm_pkg::*;

    localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
    localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int SW = SAMPLE_BITS + VW + 1;

    t_state r_state, n_state;

    logic        r_en;
    logic [2:0]  r_subdiv;
    logic [4:0]  r_beats;
    logic [15:0] r_step, r_vol;
    logic [11:0] r_hlen, r_mlen, r_slen;

    logic [1:0]    r_vkind [NUM_VOICES];
    logic [AW:0]   r_vpos  [NUM_VOICES];

    logic signed [SAMPLE_BITS-1:0] r_audio;
    logic [49:0] r_s;
    logic [17:0] r_iv;
    logic        r_phase;
    logic [VW-1:0] r_vi;
    logic        r_vhit;
    logic signed [SW-1:0] r_sum;
    logic signed [SW+16:0] r_prod;
    logic [1:0]  r_started;
    logic        r_dropped;
    logic        r_done;
    logic [15:0] r_out;

    logic        w_acc, w_mstart, w_mdone;
    logic [49:0] w_mnum;
    logic [22:0] w_mden, w_rem;
    logic [AW:0] w_len [4];
    logic [AW-1:0] w_raddr;
    logic [1:0]  w_rkind;
    logic signed [SAMPLE_BITS-1:0] w_rdata;
    logic [17:0] w_dist;
    logic [49:0] w_t;
    logic [1:0]  w_kind;
    logic signed [SW+17:0] w_n;
    logic signed [SW+17:0] w_mix;
    logic [VW:0] w_free;

    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_done;

    // Length registers clamped to table depth, indexed by kind.
    function automatic logic [AW:0] clamp(input logic [11:0] l);
        if ({20'd0, l} > TABLE_DEPTH) clamp = (AW+1)'(TABLE_DEPTH);
        else clamp = (AW+1)'(l);
    endfunction
    assign w_len[0] = '0;
    assign w_len[1] = clamp(r_hlen);
    assign w_len[2] = clamp(r_mlen);
    assign w_len[3] = clamp(r_slen);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0; r_subdiv <= 3'd1; r_beats <= 5'd4; r_step <= 16'd22;
            r_vol <= 16'd32768; r_hlen <= '0; r_mlen <= '0; r_slen <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ENABLED: r_en     <= i_cfg_data[0];
                REG_SUBDIV:  r_subdiv <= i_cfg_data[2:0];
                REG_BEATS:   r_beats  <= i_cfg_data[4:0];
                REG_STEP:    r_step   <= i_cfg_data;
                REG_VOLUME:  r_vol    <= i_cfg_data;
                REG_HLEN:    r_hlen   <= i_cfg_data[11:0];
                REG_MLEN:    r_mlen   <= i_cfg_data[11:0];
                REG_SLEN:    r_slen   <= i_cfg_data[11:0];
                default:     ;
            endcase
        end
    end

    // Shared remainder unit: grid search first, then the click kind test.
    assign w_mstart = (r_state == ST_TRIG && !r_phase) || (r_state == ST_KIND && !r_phase);
    assign w_mnum   = (r_state == ST_TRIG) ? r_s : w_t;
    assign w_mden   = (r_state == ST_TRIG) ? {5'd0, r_iv}
                                           : 23'(r_beats) * 23'(QUARTER_UNITS);
    mcvm_mod u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mstart), .i_num(w_mnum),
        .i_den(w_mden), .o_done(w_mdone), .o_rem(w_rem)
    );

    assign w_dist = (w_rem[17:0] == 18'd0) ? 18'd0 : r_iv - w_rem[17:0];
    assign w_t    = r_s - 50'(r_iv);

    // Divisibility by three from the alternating bit sum, which lies in -3..4.
    function automatic logic mult_of_three(input logic [6:0] x);
        logic [3:0] d;
        d = 4'(x[0]) + 4'(x[2]) + 4'(x[4]) + 4'(x[6]) - 4'(x[1]) - 4'(x[3]) - 4'(x[5]);
        mult_of_three = (d == 4'd0) || (d == 4'd3) || (d == 4'd13);
    endfunction

    // The bar length is a whole number of quarters, so the remainder by it is a
    // multiple of a quarter exactly when the grid point is.
    assign w_kind = (w_rem == 23'd0) ? KIND_HIGH :
                    (w_rem[15:0] == 16'd0 && mult_of_three(w_rem[22:16])) ? KIND_MID :
                    KIND_SUB;

    mcvm_tables #(.TABLE_DEPTH(TABLE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_tab (
        .i_clk(i_clk), .i_we(w_acc && s_axis_tuser[0]
                             && {1'b0, s_axis_tdata[74:64]} < 12'(TABLE_DEPTH)),
        .i_wsel(s_axis_tuser[2:1]), .i_waddr(s_axis_tdata[64 +: AW]),
        .i_wdata(s_axis_tdata[75 +: SAMPLE_BITS]),
        .i_rkind(w_rkind), .i_raddr(w_raddr), .o_rdata(w_rdata)
    );
    assign w_rkind = r_vkind[r_vi];
    assign w_raddr = r_vpos[r_vi][AW-1:0];

    // Lowest idle voice, found by a priority scan.
    always_comb begin
        w_free = (VW+1)'(NUM_VOICES);
        for (int i = NUM_VOICES - 1; i >= 0; i--) begin
            if (r_vkind[i] == KIND_IDLE) w_free = (VW+1)'(i);
        end
    end

    assign w_n   = (SW+18)'(r_prod) + (SW+18)'(16384);
    assign w_mix = (SW+18)'(r_audio) + (w_n >>> 15);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_acc && !s_axis_tuser[0]) n_state = ST_TRIG;
            ST_TRIG:  if (r_phase && w_mdone) begin
                          if (w_dist < 18'(r_step)) n_state = ST_KIND;
                          else n_state = ST_VOICE;
                      end else if (!r_phase && (r_iv == 18'd0 || !r_en
                               || r_beats == 5'd0 || r_step == 16'd0)) begin
                          n_state = ST_VOICE;
                      end
            ST_KIND:  if (r_phase && w_mdone) n_state = ST_VOICE;
            ST_VOICE: n_state = ST_WAIT;
            ST_WAIT:  if (r_vi == VW'(NUM_VOICES - 1)) n_state = ST_MIX;
                      else n_state = ST_VOICE;
            ST_MIX:   n_state = ST_SAT;
            ST_SAT:   n_state = ST_OUT;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    // Datapath and voice updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_vkind[i] <= KIND_IDLE;
                r_vpos[i]  <= '0;
            end
        end else begin
            if (r_done && m_axis_tready) r_done <= 1'b0;
            case (r_state)
                ST_IDLE: if (w_acc) begin
                    r_audio   <= s_axis_tdata[48 +: SAMPLE_BITS];
                    r_iv      <= grid_interval(r_subdiv);
                    r_s       <= 50'(s_axis_tdata[47:0]) + 50'(grid_interval(r_subdiv))
                                 - 50'(r_step[15:1]);
                    r_started <= KIND_IDLE;
                    r_dropped <= 1'b0;
                    r_phase   <= 1'b0;
                    r_sum     <= '0;
                    r_vi      <= '0;
                    if (s_axis_tuser[0]) begin
                        r_out  <= s_axis_tdata[63:48];
                        r_done <= 1'b1;
                    end
                end
                ST_TRIG: begin
                    r_phase <= !(r_phase && w_mdone);
                    if (r_phase && w_mdone) begin
                        r_s <= r_s + 50'(w_dist);
                    end
                end
                ST_KIND: begin
                    r_phase <= !(r_phase && w_mdone);
                    if (r_phase && w_mdone) begin
                        if (w_len[w_kind] == '0) r_started <= w_kind;
                        else if (w_free == (VW+1)'(NUM_VOICES)) r_dropped <= 1'b1;
                        else begin
                            r_vkind[w_free[VW-1:0]] <= w_kind;
                            r_vpos[w_free[VW-1:0]]  <= '0;
                            r_started <= w_kind;
                        end
                    end
                end
                ST_VOICE: begin
                    r_vhit <= (r_vkind[r_vi] != KIND_IDLE)
                              && (r_vpos[r_vi] < w_len[r_vkind[r_vi]]);
                end
                ST_WAIT: begin
                    if (r_vhit) r_sum <= r_sum + SW'(w_rdata);
                    if (r_vkind[r_vi] != KIND_IDLE) begin
                        if (!r_vhit || r_vpos[r_vi] + 1'b1 >= w_len[r_vkind[r_vi]]) begin
                            r_vkind[r_vi] <= KIND_IDLE;
                            r_vpos[r_vi]  <= '0;
                        end else begin
                            r_vpos[r_vi] <= r_vpos[r_vi] + 1'b1;
                        end
                    end
                    if (r_vi != VW'(NUM_VOICES - 1)) r_vi <= r_vi + 1'b1;
                end
                ST_MIX: r_prod <= r_sum * $signed({1'b0, r_vol});
                ST_SAT: begin
                    if (w_mix > (SW+18)'((1 << (SAMPLE_BITS-1)) - 1))
                        r_out <= 16'((1 << (SAMPLE_BITS-1)) - 1);
                    else if (w_mix < -(SW+18)'(1 << (SAMPLE_BITS-1)))
                        r_out <= 16'(-(1 << (SAMPLE_BITS-1)));
                    else r_out <= 16'(w_mix);
                end
                ST_OUT: r_done <= 1'b1;
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_done;
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = {r_dropped, r_started};

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_start_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(r_dropped && r_started != KIND_IDLE))
        else $error("click both started and dropped");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
`endif
endmodule

[tb/sv/metronome_click_voice_mixer_core_tb.sv]
module metronome_click_voice_mixer_core_tb;
    import mcvm_pkg::*;

    localparam int VOICES = 8;
    localparam int DEPTH = 2048;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] audio_out;
        logic [1:0]  click_started;
        logic        voice_dropped;
    } t_mix_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    // Shadow copy of the block's registers, tables and voices.
    logic        sh_enabled;
    logic [2:0]  sh_subdiv;
    logic [4:0]  sh_beats;
    logic [15:0] sh_step;
    logic [15:0] sh_volume;
    logic [11:0] sh_hlen, sh_mlen, sh_slen;
    logic signed [15:0] high_words[DEPTH];
    logic signed [15:0] mid_words[DEPTH];
    logic signed [15:0] sub_words[DEPTH];
    logic [1:0]  voice_kind[VOICES];
    logic [11:0] voice_pos[VOICES];

    t_mix_result expected_mix[$];
    int  failures = 0;
    int  results_seen = 0;
    int  clicks_seen = 0;
    int  drops_seen = 0;
    int  idle_cycles = 0;
    bit  calm = 0;
    int  out_gap = 0;

    metronome_click_voice_mixer_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Effective table length for a click kind, clamped to the table depth.
    function automatic logic [11:0] kind_len(input logic [1:0] kind);
        logic [11:0] len;
        len = (kind == KIND_HIGH) ? sh_hlen : (kind == KIND_MID) ? sh_mlen : sh_slen;
        return (len > DEPTH) ? 12'(DEPTH) : len;
    endfunction

    function automatic logic signed [15:0] kind_word(input logic [1:0] kind,
                                                     input logic [11:0] pos);
        if (kind == KIND_HIGH) return high_words[pos];
        if (kind == KIND_MID) return mid_words[pos];
        return sub_words[pos];
    endfunction

    // Grid search: which click, if any, the sample at this position starts.
    function automatic logic [1:0] grid_click(input logic [47:0] pos);
        logic [63:0] iv, half, s, r, ahead, t;
        case (sh_subdiv)
            3'd1: iv = 196608;
            3'd2: iv = 98304;
            3'd3: iv = 49152;
            3'd4: iv = 65536;
            default: iv = 0;
        endcase
        if (!sh_enabled || iv == 0 || sh_beats == 0 || sh_step == 0) return KIND_IDLE;
        half = sh_step / 2;
        s = 64'(pos) + iv - half;
        r = s % iv;
        ahead = (r == 0) ? 64'd0 : iv - r;
        if (ahead >= sh_step) return KIND_IDLE;
        t = s + ahead - iv;
        if (t % (64'(sh_beats) * 196608) == 0) return KIND_HIGH;
        if (t % 196608 == 0) return KIND_MID;
        return KIND_SUB;
    endfunction

    // Works out the mixed sample for one request and updates the shadow state.
    function automatic t_mix_result mix_sample(input logic func, input logic [47:0] pos,
                                               input logic signed [15:0] audio,
                                               input logic [1:0] sel,
                                               input logic [10:0] addr,
                                               input logic signed [15:0] value);
        t_mix_result res;
        logic [1:0]  kind;
        logic [11:0] len;
        longint      sum, n, scaled, mixed;
        int          v, slot;
        res = '0;
        if (func) begin
            if (sel == SEL_HIGH) high_words[addr] = value;
            else if (sel == SEL_MID) mid_words[addr] = value;
            else if (sel == SEL_SUB) sub_words[addr] = value;
            res.audio_out = audio;
            return res;
        end
        kind = grid_click(pos);
        if (kind != KIND_IDLE) begin
            if (kind_len(kind) == 0) begin
                res.click_started = kind;
            end else begin
                slot = -1;
                for (v = VOICES - 1; v >= 0; v--)
                    if (voice_kind[v] == KIND_IDLE) slot = v;
                if (slot >= 0) begin
                    voice_kind[slot] = kind;
                    voice_pos[slot] = 0;
                    res.click_started = kind;
                end else begin
                    res.voice_dropped = 1'b1;
                end
            end
        end
        sum = 0;
        for (v = 0; v < VOICES; v++) begin
            if (voice_kind[v] != KIND_IDLE) begin
                len = kind_len(voice_kind[v]);
                if (voice_pos[v] < len) begin
                    sum += longint'(kind_word(voice_kind[v], voice_pos[v]));
                    voice_pos[v]++;
                end
                if (voice_pos[v] >= len) begin
                    voice_kind[v] = KIND_IDLE;
                    voice_pos[v] = 0;
                end
            end
        end
        n = sum * longint'(sh_volume) + 16384;
        scaled = (n >= 0) ? n / 32768 : -((-n + 32767) / 32768);
        mixed = longint'(audio) + scaled;
        if (mixed > 32767) mixed = 32767;
        if (mixed < -32768) mixed = -32768;
        res.audio_out = mixed[15:0];
        return res;
    endfunction

    // Appends one expected result to the queue.
    task automatic add_expected(input t_mix_result res);
        expected_mix.insert(expected_mix.size(), res);
    endtask

    // Receiver side: random back-pressure, then compare each result in order.
    always @(posedge i_clk) begin
        t_mix_result exp_res;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_mix.size() == 0) begin
                    $error("result with no request outstanding: audio_out %0h", m_axis_tdata);
                    failures++;
                end else begin
                    exp_res = expected_mix.pop_front();
                    if (m_axis_tuser[1:0] != 0) clicks_seen++;
                    if (m_axis_tuser[2]) drops_seen++;
                    if (m_axis_tdata !== exp_res.audio_out) begin
                        $error("audio_out expected %0d got %0d", $signed(exp_res.audio_out),
                               $signed(m_axis_tdata));
                        failures++;
                    end
                    if (m_axis_tuser[1:0] !== exp_res.click_started) begin
                        $error("click_started expected %0d got %0d", exp_res.click_started,
                               m_axis_tuser[1:0]);
                        failures++;
                    end
                    if (m_axis_tuser[2] !== exp_res.voice_dropped) begin
                        $error("voice_dropped expected %0d got %0d", exp_res.voice_dropped,
                               m_axis_tuser[2]);
                        failures++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                out_gap = $urandom_range(1, 8);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("metronome_click_voice_mixer_core test failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            REG_ENABLED: sh_enabled = value[0];
            REG_SUBDIV:  sh_subdiv = value[2:0];
            REG_BEATS:   sh_beats = value[4:0];
            REG_STEP:    sh_step = value;
            REG_VOLUME:  sh_volume = value;
            REG_HLEN:    sh_hlen = value[11:0];
            REG_MLEN:    sh_mlen = value[11:0];
            REG_SLEN:    sh_slen = value[11:0];
            default:     ;
        endcase
    endtask

    // Sends one request after the previous one, with an optional random gap first.
    task automatic send_request(input logic func, input logic [47:0] pos,
                                input logic [15:0] audio, input logic [1:0] sel,
                                input logic [10:0] addr, input logic [15:0] value);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 8);
        @(posedge i_clk);
        repeat (gap) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, value, addr, audio, pos};
        s_axis_tuser <= {sel, func};
        do @(posedge i_clk); while (!s_axis_tready);
        add_expected(mix_sample(func, pos, audio, sel, addr, value));
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic settle();
        while (expected_mix.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // Fills the first words of each table so voices only read written words.
    task automatic fill_tables(input int words);
        int sel, a;
        logic [15:0] val;
        for (sel = 0; sel < 3; sel++)
            for (a = 0; a < words; a++) begin
                val = (a == 0) ? 16'h7fff : (a == 1) ? 16'h8000 : 16'($urandom());
                send_request(1'b1, 48'($urandom()), 16'($urandom()), 2'(sel), 11'(a), val);
            end
    endtask

    // Table writes at extreme fields, including the ignored selector.
    task automatic test_table_writes();
        send_request(1'b1, 48'hffff_ffff_ffff, 16'h7fff, SEL_HIGH, 11'h7ff, 16'h8000);
        send_request(1'b1, 48'h0, 16'h8000, SEL_MID, 11'h7ff, 16'h7fff);
        send_request(1'b1, 48'h5555_5555_5555, 16'h0, SEL_SUB, 11'h7ff, 16'hffff);
        send_request(1'b1, 48'haaaa_aaaa_aaaa, 16'h1234, 2'd3, 11'h0, 16'h5a5a);
        fill_tables(64);
        settle();
    endtask

    // Grid hits across the subdivisions, with saturation and zero-length clicks.
    task automatic test_directed_clicks();
        int sd;
        write_reg(REG_ENABLED, 16'd1);
        write_reg(REG_HLEN, 16'd40);
        write_reg(REG_MLEN, 16'd0);
        write_reg(REG_SLEN, 16'd3000);
        write_reg(REG_VOLUME, 16'hffff);
        for (sd = 1; sd <= 4; sd++) begin
            write_reg(REG_SUBDIV, 16'(sd));
            send_request(1'b0, 48'd0, 16'h7fff, 2'd0, 11'd0, 16'd0);
            send_request(1'b0, 48'd196608, 16'h8000, 2'd0, 11'd0, 16'd0);
            send_request(1'b0, 48'd65536 + 48'd5, 16'h0, 2'd0, 11'd0, 16'd0);
            send_request(1'b0, 48'd49152 - 48'd11, 16'h0, 2'd0, 11'd0, 16'd0);
            settle();
            write_reg(REG_HLEN, 16'd2);
        end
        write_reg(REG_SLEN, 16'd64);
        settle();
    endtask

    // Random positions around grid points under varied settings.
    task automatic test_random_mix(input int count);
        int k, j;
        logic [47:0] pos;
        for (k = 0; k < count; k++) begin
            if (k % 150 == 0) begin
                settle();
                write_reg(REG_ENABLED, 16'($urandom_range(0, 5) != 0));
                write_reg(REG_SUBDIV, 16'($urandom_range(0, 7)));
                j = $urandom_range(0, 9);
                write_reg(REG_BEATS, j == 0 ? 16'd0 : j == 1 ? 16'd31 :
                          j == 2 ? 16'd16 : 16'($urandom_range(1, 7)));
                j = $urandom_range(0, 9);
                write_reg(REG_STEP, j == 0 ? 16'd0 : j == 1 ? 16'hffff :
                          j == 2 ? 16'd1 : 16'($urandom_range(2, 4000)));
                j = $urandom_range(0, 3);
                write_reg(REG_VOLUME, j == 0 ? 16'd0 : j == 1 ? 16'hffff : 16'($urandom()));
                write_reg(REG_HLEN, 16'($urandom_range(0, 64)));
                write_reg(REG_MLEN, 16'($urandom_range(0, 64)));
                write_reg(REG_SLEN, 16'($urandom_range(0, 64)));
            end
            if ($urandom_range(0, 19) == 0) begin
                send_request(1'b1, {$urandom(), 16'($urandom())}, 16'($urandom()),
                             2'($urandom_range(0, 3)), 11'($urandom_range(0, 63)),
                             16'($urandom()));
            end else begin
                j = $urandom_range(0, 3);
                pos = (j == 0) ? {$urandom(), 16'($urandom())} :
                      48'(64'($urandom_range(0, 200)) * 49152 +
                          $urandom_range(0, 4000) - 2000);
                send_request(1'b0, pos, 16'($urandom()), 2'($urandom()), 11'($urandom()),
                             16'($urandom()));
            end
        end
        settle();
    endtask

    // Dense clicks with long tables so every voice is busy and clicks drop.
    task automatic test_voice_overflow();
        int k;
        write_reg(REG_ENABLED, 16'd1);
        write_reg(REG_SUBDIV, 16'd3);
        write_reg(REG_BEATS, 16'd4);
        write_reg(REG_STEP, 16'hffff);
        write_reg(REG_VOLUME, 16'd32768);
        write_reg(REG_HLEN, 16'd64);
        write_reg(REG_MLEN, 16'd64);
        write_reg(REG_SLEN, 16'd64);
        for (k = 0; k < 30; k++)
            send_request(1'b0, 48'(k * 49152), 16'($urandom()), 2'd0, 11'd0, 16'd0);
        settle();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        sh_enabled = 0; sh_subdiv = 1; sh_beats = 4; sh_step = 22; sh_volume = 16'h8000;
        sh_hlen = 0; sh_mlen = 0; sh_slen = 0;
        foreach (voice_kind[v]) begin
            voice_kind[v] = KIND_IDLE;
            voice_pos[v] = 0;
        end
        foreach (high_words[a]) begin
            high_words[a] = 0; mid_words[a] = 0; sub_words[a] = 0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_table_writes();
        test_directed_clicks();
        test_voice_overflow();
        test_random_mix(1050);
        calm = 1;
        test_random_mix(200);
        settle();
        $display("Covered %0d results, %0d clicks started, %0d clicks dropped.",
                 results_seen, clicks_seen, drops_seen);
        $display("Table writes, all subdivisions, saturation and voice overflow were run.");
        if (failures == 0)
            $display("metronome_click_voice_mixer_core test passed");
        else
            $display("metronome_click_voice_mixer_core test failed");
        $finish;
    end

endmodule
